// ===== hdl/rwtp_pkg.sv =====
package rwtp_pkg;

  localparam int MAX_RESULTS   = 3;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [31:0] WORD_HEADER = 32'hffff_ffff;
  localparam logic [31:0] WORD_EOF    = 32'he000_0000;
  localparam logic [15:0] MODULE_LO   = 16'hffff;
  localparam logic [7:0]  MODULE_HI   = 8'hf1;

  localparam logic [3:0] TAG_CHANNEL = 4'h1;
  localparam logic [3:0] TAG_ADC_A   = 4'h2;
  localparam logic [3:0] TAG_ADC_B   = 4'h3;
  localparam logic [3:0] TAG_TIME_LO = 4'h4;
  localparam logic [3:0] TAG_TIME_HI = 4'h7;

  localparam logic [3:0] HDR_COUNT_MAX   = 4'd15;
  localparam logic [3:0] HDR_FRAME_HIGH  = 4'd5;
  localparam logic [3:0] HDR_FRAME_LOW   = 4'd8;

  localparam logic [15:0] COUNT_MAX = 16'hffff;
  localparam logic [27:0] SUM_MAX   = 28'hfff_ffff;

  localparam logic KIND_PULSE  = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [23:0] frame_number;
    logic [4:0]  module_res;
    logic [5:0]  channel;
    logic [13:0] time_tick;
    logic [11:0] peak;
    logic [15:0] sample_count;
    logic [27:0] sum;
  } result_t;

  // results caused by one word, packed to the front; n is 1..3
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                n;
  } entry_t;

endpackage

// ===== hdl/rwtp_front.sv =====
module rwtp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      word,
  input  logic             q_full,
  output logic             push,
  output rwtp_pkg::entry_t push_entry
);
  import rwtp_pkg::*;

  typedef struct packed {
    logic [5:0]  channel;
    logic [13:0] time_tick;
    logic [15:0] count;
    logic [11:0] peak;
    logic [27:0] sum;
  } region_t;

  typedef struct packed {
    region_t region;
    logic    fire;
  } dec_t;

  function automatic dec_t decode_half(input logic [15:0] h, input region_t r);
    dec_t        d;
    logic [3:0]  tag;
    logic [11:0] v;
    logic [28:0] s;
    d.region = r;
    d.fire   = 1'b0;
    tag      = h[15:12];
    v        = h[11:0];
    s        = {1'b0, r.sum} + {17'd0, v};
    if (tag == TAG_CHANNEL) begin
      d.region.channel = h[5:0];
      d.region.count   = '0;
      d.region.peak    = '0;
      d.region.sum     = '0;
    end else if (tag inside {[TAG_TIME_LO:TAG_TIME_HI]}) begin
      d.fire             = (r.count != '0) && (r.peak != '0) && (r.sum != '0);
      d.region.time_tick = h[13:0];
      d.region.count     = '0;
      d.region.peak      = '0;
      d.region.sum       = '0;
    end else if (tag inside {TAG_ADC_A, TAG_ADC_B}) begin
      if (r.count != COUNT_MAX) d.region.count = r.count + 16'd1;
      if (v > r.peak) d.region.peak = v;
      d.region.sum = (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[27:0];
    end
    return d;
  endfunction

  logic        header_active, header_active_next;
  logic [3:0]  header_count, header_count_next;
  logic [11:0] frame_high, frame_high_next;
  logic [5:0]  frame_mid, frame_mid_next;
  logic [23:0] current_frame, current_frame_next;
  logic [23:0] expected_frame, expected_frame_next;
  logic [4:0]  module_reg, module_reg_next;
  region_t     region, region_next;

  logic [15:0] lo, hi;
  dec_t        dec_lo, dec_hi;
  logic        notice;
  logic        frame_sel_hi, frame_take;
  logic [5:0]  frame_low;
  result_t     r_notice, r_lo, r_hi;
  entry_t      entry;
  logic [1:0]  k;

  assign lo       = word[15:0];
  assign hi       = word[31:16];
  assign in_ready = !q_full;

  always_comb begin
    header_active_next  = header_active;
    header_count_next   = header_count;
    frame_high_next     = frame_high;
    frame_mid_next      = frame_mid;
    current_frame_next  = current_frame;
    expected_frame_next = expected_frame;
    module_reg_next     = module_reg;
    notice              = 1'b0;
    frame_take          = 1'b0;
    frame_sel_hi        = 1'b0;
    frame_low           = lo[11:6];

    if (header_active) begin
      if (header_count < HDR_COUNT_MAX) header_count_next = header_count + 4'd1;
      if (header_count_next == HDR_FRAME_HIGH) begin
        frame_high_next = lo[11:0];
        frame_mid_next  = hi[11:6];
      end else if (header_count_next == HDR_FRAME_LOW) begin
        if (lo[15:12] == TAG_CHANNEL) begin
          frame_take = 1'b1;
        end else if (hi[15:12] == TAG_CHANNEL) begin
          frame_take   = 1'b1;
          frame_sel_hi = 1'b1;
        end
      end
    end
    if (frame_sel_hi) frame_low = hi[11:6];
    if (frame_take) begin
      current_frame_next  = {frame_high, frame_mid, frame_low};
      notice              = (current_frame_next != expected_frame);
      expected_frame_next = current_frame_next + 24'd1;
      header_active_next  = 1'b0;
      header_count_next   = '0;
    end

    if (hi[15:8] == MODULE_HI && lo == MODULE_LO) module_reg_next = hi[4:0];

    dec_lo      = decode_half(lo, region);
    dec_hi      = decode_half(hi, dec_lo.region);
    region_next = dec_hi.region;

    // header and end-of-frame words touch nothing but the header tracker
    if (word == WORD_HEADER) begin
      header_active_next  = 1'b1;
      header_count_next   = 4'd1;
      frame_high_next     = frame_high;
      frame_mid_next      = frame_mid;
      current_frame_next  = current_frame;
      expected_frame_next = expected_frame;
      module_reg_next     = module_reg;
      region_next         = region;
      notice              = 1'b0;
      dec_lo.fire         = 1'b0;
      dec_hi.fire         = 1'b0;
    end else if (word == WORD_EOF) begin
      header_active_next  = header_active;
      header_count_next   = header_count;
      frame_high_next     = frame_high;
      frame_mid_next      = frame_mid;
      current_frame_next  = current_frame;
      expected_frame_next = expected_frame;
      module_reg_next     = module_reg;
      region_next         = region;
      notice              = 1'b0;
      dec_lo.fire         = 1'b0;
      dec_hi.fire         = 1'b0;
    end
  end

  // notice carries the module number from before this word's module update
  always_comb begin
    r_notice              = '0;
    r_notice.kind         = KIND_NOTICE;
    r_notice.frame_number = current_frame_next;
    r_notice.module_res   = module_reg;

    r_lo.kind         = KIND_PULSE;
    r_lo.frame_number = current_frame_next;
    r_lo.module_res   = module_reg_next;
    r_lo.channel      = region.channel;
    r_lo.time_tick    = region.time_tick;
    r_lo.peak         = region.peak;
    r_lo.sample_count = region.count;
    r_lo.sum          = region.sum;

    r_hi.kind         = KIND_PULSE;
    r_hi.frame_number = current_frame_next;
    r_hi.module_res   = module_reg_next;
    r_hi.channel      = dec_lo.region.channel;
    r_hi.time_tick    = dec_lo.region.time_tick;
    r_hi.peak         = dec_lo.region.peak;
    r_hi.sample_count = dec_lo.region.count;
    r_hi.sum          = dec_lo.region.sum;

    entry = '0;
    k     = '0;
    if (notice) begin
      entry.res[k] = r_notice;
      k            = k + 2'd1;
    end
    if (dec_lo.fire) begin
      entry.res[k] = r_lo;
      k            = k + 2'd1;
    end
    if (dec_hi.fire) begin
      entry.res[k] = r_hi;
      k            = k + 2'd1;
    end
    entry.n = k;
  end

  assign push       = in_valid && in_ready && (entry.n != '0);
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_active  <= 1'b0;
      header_count   <= '0;
      frame_high     <= '0;
      frame_mid      <= '0;
      current_frame  <= '0;
      expected_frame <= '0;
      module_reg     <= '0;
      region         <= '0;
    end else if (in_valid && in_ready) begin
      header_active  <= header_active_next;
      header_count   <= header_count_next;
      frame_high     <= frame_high_next;
      frame_mid      <= frame_mid_next;
      current_frame  <= current_frame_next;
      expected_frame <= expected_frame_next;
      module_reg     <= module_reg_next;
      region         <= region_next;
    end
  end

endmodule

// ===== hdl/rwtp_queue.sv =====
module rwtp_queue #(
  parameter int DEPTH = rwtp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rwtp_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output rwtp_pkg::entry_t head
);
  import rwtp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  entry_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full       = (count == DEPTH_C);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CW'(1))
    else $error("push lost");

endmodule

// ===== hdl/rwtp_back.sv =====
module rwtp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  rwtp_pkg::entry_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output rwtp_pkg::result_t out_res,
  output logic              out_last
);
  import rwtp_pkg::*;

  logic [1:0] idx;
  logic       load, is_last;

  assign load    = head_valid && (!out_valid || out_ready);
  assign is_last = (idx == head.n - 2'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= head.res[idx];
      out_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idx_in_entry: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < head.n)
    else $error("slot index past entry");
  a_idx_zero_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> idx == 2'd0)
    else $error("slot index left open");

endmodule

// ===== hdl/readout_word_trigger_primitive_finder_core.sv =====
// The first result of a word is registered in the entry queue and then in the output register.
// The front takes one word per cycle while each word yields at most one result and the queue
//   is not full; a word with k results (k up to 3) holds the output side for k transfers.
// The entry queue (QUEUE_DEPTH words) absorbs bursts; input stalls when it fills.
// Reset (rst, synchronous, active high): all tracking state to zero, queue
//   empty, no result valid.
module readout_word_trigger_primitive_finder_core #(
  parameter int QUEUE_DEPTH = rwtp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [23:0] frame_number,
  output logic [4:0]  module_res,
  output logic [5:0]  channel,
  output logic [13:0] time_tick,
  output logic [11:0] peak,
  output logic [15:0] sample_count,
  output logic [27:0] sum,
  output logic        last
);
  import rwtp_pkg::*;

  // front: header/frame tracking, module word, half-word decode; one word per cycle
  // while the queue is not full, all results of a word bundled into one queue entry
  logic    q_full, push, pop, head_valid;
  entry_t  push_entry, head;
  result_t res;

  rwtp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .word       (word),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // words that cause no result never enter the queue
  rwtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: walks the entry's results into the output register, one a transfer
  rwtp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (res),
    .out_last   (last)
  );

  assign kind         = res.kind;
  assign frame_number = res.frame_number;
  assign module_res   = res.module_res;
  assign channel      = res.channel;
  assign time_tick    = res.time_tick;
  assign peak         = res.peak;
  assign sample_count = res.sample_count;
  assign sum          = res.sum;

endmodule
